[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Request and status codes, store geometry and the command and status
// bundles between the list controller and the list datapath.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int REQ_W    = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int CMP_W    = POS_W + 1;
  localparam int S_DATA_W = POS_W + VAL_W;
  localparam int M_DATA_W = VAL_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_DELETE  = 3'd1,
    REQ_SHOW_FW = 3'd2,
    REQ_SEARCH  = 3'd3,
    REQ_SHOW_RV = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5,
    ST_INVALID  = 3'd6
  } status_t;

  // Where the walk pointer starts.
  typedef enum logic [1:0] {
    PTR_ZERO = 2'd0,
    PTR_LAST = 2'd1,
    PTR_POS  = 2'd2
  } ptr_sel_t;

  // How many reads the walk makes.
  typedef enum logic {
    LEFT_ALL  = 1'b0,
    LEFT_TAIL = 1'b1
  } left_sel_t;

  // Which value goes out with a result word.
  typedef enum logic [1:0] {
    ITEM_ZERO    = 2'd0,
    ITEM_RDATA   = 2'd1,
    ITEM_REMOVED = 2'd2
  } item_sel_t;

  typedef struct packed {
    logic      load;
    logic      init;
    ptr_sel_t  ptr_sel;
    left_sel_t left_sel;
    logic      rd;
    logic      dir_down;
    logic      take;
    logic      grab;
    logic      wr_shift;
    logic      wr_val;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    status_t   status;
    item_sel_t item_sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             ins_bad;
    logic             del_bad;
    logic             full;
    logic             empty;
    logic             done;
    logic             pend;
    logic             first;
    logic             hit;
    logic             found;
    logic             out_free;
  } stat_t;

endpackage

[hw/rtl/ple_ram.sv]
// ----------------------------------------------------------------------------
// ple_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ple_dp.sv]
// ----------------------------------------------------------------------------
// ple_dp: list datapath
// Request registers, element count, walk pointer and read counter, the
// element store and the result word register.
// ----------------------------------------------------------------------------
module ple_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [ple_pkg::REQ_W-1:0]     s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [ple_pkg::M_DATA_W-1:0]  m_tdata,
  output logic [ple_pkg::STAT_W-1:0]    m_tuser,
  output logic                          m_tlast,
  input  ple_pkg::cmd_t                 cmd,
  output ple_pkg::stat_t                st
);

  localparam int AW  = ple_pkg::ADDR_W;
  localparam int CW  = ple_pkg::CNT_W;
  localparam int PW  = ple_pkg::POS_W;
  localparam int VW  = ple_pkg::VAL_W;
  localparam int XW  = ple_pkg::CMP_W;
  localparam int CAP = ple_pkg::CAPACITY;

  logic [ple_pkg::REQ_W-1:0] req;
  logic [PW-1:0]             pos;
  logic [VW-1:0]             value;
  logic [CW-1:0]             count;
  logic [AW-1:0]             ptr;
  logic [AW-1:0]             ptr_q;
  logic [CW-1:0]             left;
  logic                      pend;
  logic                      first;
  logic                      found;
  logic [VW-1:0]             removed;
  logic [VW-1:0]             rdata;

  logic [XW-1:0] pos_ext;
  logic [XW-1:0] cnt_ext;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] last_idx;
  logic [CW-1:0] tail_len;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [VW-1:0] item_next;

  assign pos_ext  = XW'(pos);
  assign cnt_ext  = XW'(count);
  assign pos_idx  = AW'(pos - PW'(1));
  assign last_idx = AW'(count - CW'(1));
  assign tail_len = CW'(cnt_ext - pos_ext + XW'(1));

  always_comb begin
    st          = '0;
    st.req      = req;
    st.ins_bad  = (pos == '0) || (pos_ext > cnt_ext + XW'(1));
    st.del_bad  = (pos == '0) || (pos_ext > cnt_ext);
    st.full     = (count == CW'(CAP));
    st.empty    = (count == '0);
    st.done     = (left == '0);
    st.pend     = pend;
    st.first    = first;
    st.hit      = (rdata == value);
    st.found    = found;
    st.out_free = !m_tvalid || m_tready;
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= s_tuser;
      pos   <= s_tdata[PW-1:0];
      value <= s_tdata[PW +: VW];
    end
  end

  // Walk pointer: a read goes out at ptr, then ptr steps.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      case (cmd.ptr_sel)
        ple_pkg::PTR_ZERO: ptr <= '0;
        ple_pkg::PTR_LAST: ptr <= last_idx;
        ple_pkg::PTR_POS:  ptr <= pos_idx;
        default:           ptr <= '0;
      endcase
    end else if (cmd.rd) begin
      ptr   <= cmd.dir_down ? ptr - AW'(1) : ptr + AW'(1);
      ptr_q <= ptr;
    end
    if (cmd.grab) begin
      removed <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      left  <= '0;
      pend  <= 1'b0;
      first <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.init) begin
        left  <= (cmd.left_sel == ple_pkg::LEFT_TAIL) ? tail_len : count;
        first <= 1'b1;
        found <= 1'b0;
      end else begin
        if (cmd.rd) begin
          left <= left - CW'(1);
        end
        if (cmd.take) begin
          first <= 1'b0;
          if (rdata == value) begin
            found <= 1'b1;
          end
        end
      end
      if (cmd.rd) begin
        pend <= 1'b1;
      end else if (cmd.take) begin
        pend <= 1'b0;
      end
    end
  end

  // Insert moves entries up one place, delete moves them down one place.
  assign waddr = cmd.wr_val ? pos_idx : (cmd.dir_down ? ptr_q + AW'(1) : ptr_q - AW'(1));
  assign wdata = cmd.wr_val ? value : rdata;

  ple_ram #(
    .WIDTH (VW),
    .DEPTH (CAP)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_shift || cmd.wr_val),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (ptr),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.item_sel)
      ple_pkg::ITEM_RDATA:   item_next = rdata;
      ple_pkg::ITEM_REMOVED: item_next = removed;
      default:               item_next = '0;
    endcase
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= item_next;
      m_tuser <= cmd.status;
      m_tlast <= cmd.last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == $past(count) + CW'(1)) || (count == $past(count) - CW'(1)))
    else $error("element count moved by more than one");

endmodule

[hw/rtl/ple_ctrl.sv]
// ----------------------------------------------------------------------------
// ple_ctrl: list controller
// Decodes each request and sequences the datapath walk: shift up for
// insert, shift down for delete, streamed reads for display and search.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output ple_pkg::cmd_t  cmd,
  input  ple_pkg::stat_t st
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_SHIFT_UP = 9'b000000100,
    S_WR_VAL   = 9'b000001000,
    S_SHIFT_DN = 9'b000010000,
    S_SHOW     = 9'b000100000,
    S_SEARCH   = 9'b001000000,
    S_FIN      = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.status   = ple_pkg::ST_DONE;
    cmd.item_sel = ple_pkg::ITEM_ZERO;
    cmd.ptr_sel  = ple_pkg::PTR_ZERO;
    cmd.left_sel = ple_pkg::LEFT_ALL;
    cmd.last     = 1'b1;
    case (state)
      S_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        case (st.req)
          ple_pkg::REQ_INSERT: begin
            if (st.ins_bad || st.full) begin
              cmd.status = st.ins_bad ? ple_pkg::ST_BADPOS : ple_pkg::ST_FULL;
              cmd.emit   = st.out_free;
              if (st.out_free) begin
                state_next = S_IDLE;
              end
            end else begin
              cmd.init     = 1'b1;
              cmd.ptr_sel  = ple_pkg::PTR_LAST;
              cmd.left_sel = ple_pkg::LEFT_TAIL;
              state_next   = S_SHIFT_UP;
            end
          end
          ple_pkg::REQ_DELETE: begin
            if (st.del_bad) begin
              cmd.status = ple_pkg::ST_BADPOS;
              cmd.emit   = st.out_free;
              if (st.out_free) begin
                state_next = S_IDLE;
              end
            end else begin
              cmd.init     = 1'b1;
              cmd.ptr_sel  = ple_pkg::PTR_POS;
              cmd.left_sel = ple_pkg::LEFT_TAIL;
              state_next   = S_SHIFT_DN;
            end
          end
          ple_pkg::REQ_SHOW_FW, ple_pkg::REQ_SHOW_RV: begin
            if (st.empty) begin
              cmd.status = ple_pkg::ST_EMPTY;
              cmd.emit   = st.out_free;
              if (st.out_free) begin
                state_next = S_IDLE;
              end
            end else begin
              cmd.init    = 1'b1;
              cmd.ptr_sel = (st.req == ple_pkg::REQ_SHOW_RV) ? ple_pkg::PTR_LAST
                                                              : ple_pkg::PTR_ZERO;
              state_next  = S_SHOW;
            end
          end
          ple_pkg::REQ_SEARCH: begin
            cmd.init   = 1'b1;
            state_next = S_SEARCH;
          end
          default: begin
            cmd.status = ple_pkg::ST_INVALID;
            cmd.emit   = st.out_free;
            if (st.out_free) begin
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_SHIFT_UP: begin
        cmd.dir_down = 1'b1;
        cmd.rd       = !st.done;
        cmd.take     = st.pend;
        cmd.wr_shift = st.pend;
        if (st.done && !st.pend) begin
          state_next = S_WR_VAL;
        end
      end

      S_WR_VAL: begin
        cmd.wr_val  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FIN;
      end

      S_SHIFT_DN: begin
        cmd.rd       = !st.done;
        cmd.take     = st.pend;
        cmd.grab     = st.pend && st.first;
        cmd.wr_shift = st.pend && !st.first;
        if (st.done && !st.pend) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FIN;
        end
      end

      S_SHOW: begin
        cmd.dir_down = (st.req == ple_pkg::REQ_SHOW_RV);
        cmd.emit     = st.pend && st.out_free;
        cmd.take     = cmd.emit;
        cmd.item_sel = ple_pkg::ITEM_RDATA;
        cmd.last     = st.done;
        cmd.rd       = !st.done && (!st.pend || cmd.emit);
        if (cmd.emit && st.done) begin
          state_next = S_IDLE;
        end
      end

      S_SEARCH: begin
        cmd.take = st.pend;
        cmd.rd   = !st.done && !(st.pend && st.hit);
        if ((st.pend && st.hit) || (st.done && !st.pend)) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        cmd.emit = st.out_free;
        case (st.req)
          ple_pkg::REQ_DELETE: cmd.item_sel = ple_pkg::ITEM_REMOVED;
          ple_pkg::REQ_SEARCH: cmd.status = st.found ? ple_pkg::ST_FOUND
                                                     : ple_pkg::ST_NOTFOUND;
          default:             cmd.item_sel = ple_pkg::ITEM_ZERO;
        endcase
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Insert, delete, search and forward or reverse display over a list of
// up to 32 elements held in a single-port-read RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request word enters on the slave channel; its kind (insert, delete,
//   show forward, search, show reverse) rides in s_tuser, position and
//   value in s_tdata. Result words leave on the master channel: status in
//   m_tuser, the deleted or displayed value in m_tdata, and m_tlast high on
//   the final word of the request. Display of a non-empty list emits one word
//   per element; every other request gives exactly one word.
//   One request is in work at a time; s_tready is high only while the
//   controller is idle, entered as the final result word is loaded, so a
//   request is taken while that word may still wait for the receiver.
//   Errors, unknown requests and empty display are answered from the decode
//   state with no walk. The walk touches one element per cycle through the
//   single read port; a display pauses while the receiver stalls and
//   otherwise loads one result word per cycle.
//   Reset empties the list at once (the element count goes to zero); the
//   store itself is not cleared. A stalled receiver holds the result word
//   in the output register; the request then pauses until the word is
//   taken, and no word is lost.
// ----------------------------------------------------------------------------
module positional_list_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ple_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] position, [39:8] value
  input  logic [ple_pkg::REQ_W-1:0]    s_tuser,   // [2:0] req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ple_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] item_value
  output logic [ple_pkg::STAT_W-1:0]   m_tuser,   // [2:0] status
  output logic                         m_tlast
);

  ple_pkg::cmd_t  cmd;
  ple_pkg::stat_t st;

  // Sequence each request.
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  // Hold the list and drive result words.
  ple_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .st       (st)
  );

  // Never overwrite a result word the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result word overwritten while stalled");

  // No stale read data may remain when a new request can enter.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !st.pend)
    else $error("read data pending while idle");

endmodule

[test/positional_list_engine_tb.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_tb: self-checking bench for the positional list engine
// Streams insert, delete, search, display and unknown requests into the
// block, keeps its own copy of the list to work out every result word, and
// compares each word on the master channel with the oldest one expected.
// Both channels idle at random; one long receiver hold-off backs the block
// up, and one request waits until every result word has drained.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import ple_pkg::*;

  // Request codes the block does not know; each must answer ST_INVALID.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID   = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  localparam int RANDOM_ITEMS    = 50;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int TAIL_CYCLES     = 48;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               gap_max;      // sender gap drawn after this word
    int               sink_max;     // receiver stall drawn per result word
    bit               drain_first;  // hold this word until all results are in
    bit               hold_sink;    // start the long receiver hold-off
  } list_request_t;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] item;
    logic             last;
  } list_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [REQ_W-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]   m_tuser;
  logic                m_tlast;

  // Pending requests, filled by the stimulus process and drained by the driver.
  list_request_t request_q[$];
  // Result words the list should produce, oldest first.
  list_word_t    word_q[$];

  // Our copy of the list contents.
  logic [VAL_W-1:0] list_copy[CAPACITY];
  int               list_len = 0;

  int words_predicted = 0;
  int words_seen      = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int sink_stall_max  = 0;
  int hold_off_asks   = 0;

  // Stimulus knobs; the generator tracks the list length on its own.
  int gen_len      = 0;
  int gen_gap_max  = 9;
  int gen_sink_max = 9;
  bit gen_drain    = 1'b0;
  bit gen_hold     = 1'b0;

  positional_list_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // List prediction
  // --------------------------------------------------------------------------
  function automatic void expect_word(status_t status, logic [VAL_W-1:0] item, logic last);
    list_word_t w;
    w.status = status;
    w.item   = item;
    w.last   = last;
    word_q.push_back(w);
    words_predicted++;
  endfunction

  // Apply one accepted request to the list copy and queue its result words.
  function automatic void apply_list_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                             logic [VAL_W-1:0] val);
    int p;
    int n;
    int k;
    bit hit;
    logic [VAL_W-1:0] removed;
    p   = pos;
    n   = list_len;
    hit = 1'b0;
    case (req)
      REQ_INSERT: begin
        if (p < 1 || p > n + 1) begin
          expect_word(ST_BADPOS, '0, 1'b1);
        end else if (n >= CAPACITY) begin
          expect_word(ST_FULL, '0, 1'b1);
        end else begin
          // shift the tail up by one, then drop the value into the gap
          for (k = n; k > p - 1; k--) list_copy[k] = list_copy[k-1];
          list_copy[p-1] = val;
          list_len = n + 1;
          expect_word(ST_DONE, '0, 1'b1);
        end
      end
      REQ_DELETE: begin
        if (p < 1 || p > n) begin
          expect_word(ST_BADPOS, '0, 1'b1);
        end else begin
          removed = list_copy[p-1];
          for (k = p - 1; k + 1 < n; k++) list_copy[k] = list_copy[k+1];
          list_len = n - 1;
          expect_word(ST_DONE, removed, 1'b1);
        end
      end
      REQ_SHOW_FW, REQ_SHOW_RV: begin
        if (n == 0) begin
          expect_word(ST_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < n; k++)
            expect_word(ST_DONE, (req == REQ_SHOW_FW) ? list_copy[k] : list_copy[n-1-k],
                        k + 1 == n);
        end
      end
      REQ_SEARCH: begin
        for (k = 0; k < n; k++) if (list_copy[k] == val) hit = 1'b1;
        expect_word(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b1);
      end
      default: begin
        expect_word(ST_INVALID, '0, 1'b1);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_request(logic [REQ_W-1:0] req, int pos, logic [VAL_W-1:0] val);
    list_request_t r;
    r.req         = req;
    r.pos         = pos[POS_W-1:0];
    r.val         = val;
    r.gap_max     = gen_gap_max;
    r.sink_max    = gen_sink_max;
    r.drain_first = gen_drain;
    r.hold_sink   = gen_hold;
    gen_drain     = 1'b0;
    gen_hold      = 1'b0;
    request_q.push_back(r);
    // track the length so later positions can aim at the valid range
    if (req == REQ_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (req == REQ_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
  endfunction

  // Half full-range values, half small ones so that searches hit now and then.
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return VAL_W'(int'($urandom_range(0, 7)) - 4);
  endfunction

  function automatic int pick_position(logic [REQ_W-1:0] req);
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 0;
      1: return $urandom_range(0, 255);
      2: return gen_len + 1 + $urandom_range(0, 1);
      3: return 255;
      default: begin
        if (req == REQ_INSERT) return $urandom_range(1, gen_len + 1);
        return (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
      end
    endcase
  endfunction

  function automatic void add_random_request();
    int r;
    logic [REQ_W-1:0] req;
    r = $urandom_range(0, 99);
    if (r < 38)      req = REQ_INSERT;
    else if (r < 62) req = REQ_DELETE;
    else if (r < 70) req = REQ_SHOW_FW;
    else if (r < 78) req = REQ_SHOW_RV;
    else if (r < 94) req = REQ_SEARCH;
    else             req = REQ_SPARE_FIRST + REQ_W'($urandom_range(0, 2));
    add_request(req, pick_position(req), pick_value());
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    // directed: empty list, position bounds, value extremes, unknown codes
    add_request(REQ_SHOW_FW, 0, '0);
    add_request(REQ_SHOW_RV, 0, '0);
    add_request(REQ_SEARCH, 0, '0);
    add_request(REQ_DELETE, 1, '0);
    add_request(REQ_INSERT, 0, 32'h1234_5678);
    add_request(REQ_INSERT, 2, 32'h1234_5678);
    add_request(REQ_INSERT, 1, 32'h7fff_ffff);
    add_request(REQ_INSERT, 1, 32'h8000_0000);
    add_request(REQ_INSERT, 3, 32'hffff_ffff);
    add_request(REQ_INSERT, 2, 32'h0000_0000);
    add_request(REQ_SHOW_FW, 0, '0);
    add_request(REQ_SHOW_RV, 255, 32'hffff_ffff);
    add_request(REQ_SEARCH, 0, 32'h7fff_ffff);
    add_request(REQ_SEARCH, 0, 32'h0001_2345);
    add_request(REQ_DELETE, 0, '0);
    add_request(REQ_DELETE, 5, '0);
    add_request(REQ_DELETE, 255, '0);
    add_request(REQ_INSERT, 255, 32'h5555_5555);
    add_request(REQ_SPARE_FIRST, 0, '0);
    add_request(REQ_SPARE_MID, 255, 32'hffff_ffff);
    add_request(REQ_SPARE_LAST, 7, 32'haaaa_aaaa);
    add_request(REQ_DELETE, 4, '0);
    add_request(REQ_DELETE, 1, '0);
    add_request(REQ_SHOW_FW, 0, '0);

    // random mix, both sides idling
    repeat (RANDOM_ITEMS) add_random_request();

    // fill to capacity back to back, no idling on either side
    gen_gap_max  = 0;
    gen_sink_max = 0;
    while (gen_len < CAPACITY) add_request(REQ_INSERT, $urandom_range(1, gen_len + 1),
                                           pick_value());
    add_request(REQ_INSERT, 1, pick_value());
    add_request(REQ_INSERT, CAPACITY + 1, pick_value());
    add_request(REQ_INSERT, CAPACITY + 2, pick_value());
    // long receiver hold-off under a full display while the sender keeps offering
    gen_hold = 1'b1;
    add_request(REQ_SHOW_FW, 0, '0);
    add_request(REQ_SHOW_RV, 0, '0);
    add_request(REQ_SEARCH, 0, pick_value());
    add_request(REQ_DELETE, CAPACITY, '0);

    // pause the sender until everything is out, then random mix with idling
    gen_gap_max  = 9;
    gen_sink_max = 9;
    gen_drain    = 1'b1;
    repeat (RANDOM_ITEMS) add_random_request();

    // empty the list from random positions
    while (gen_len > 0) add_request(REQ_DELETE, $urandom_range(1, gen_len), '0);
    add_request(REQ_SHOW_RV, 0, '0);

    // sender back to back, receiver stalling; then the other way round
    gen_gap_max = 0;
    repeat (RANDOM_ITEMS - 10) add_random_request();
    gen_gap_max  = 9;
    gen_sink_max = 0;
    repeat (RANDOM_ITEMS - 20) add_random_request();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // wait for the last request to go in and its words to come out
    do @(negedge clk);
    while (request_q.size() != 0 || s_tvalid || words_seen != words_predicted);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && word_q.size() == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present requests, predict on acceptance
  // --------------------------------------------------------------------------
  int            gap_left = 0;
  list_request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) apply_list_request(s_tuser, s_tdata[POS_W-1:0],
                                                   s_tdata[POS_W+:VAL_W]);
      // hold the word while it waits for ready
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain_first || words_predicted == words_seen)) begin
          next_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= next_req.req;
          s_tdata  <= {next_req.val, next_req.pos};
          gap_left = $urandom_range(0, next_req.gap_max);
          sink_stall_max <= next_req.sink_max;
          if (next_req.hold_sink) hold_off_asks <= hold_off_asks + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result word, drive ready with stalls and hold-offs
  // --------------------------------------------------------------------------
  int         stall_left    = 0;
  int         hold_off_left = 0;
  int         hold_off_seen = 0;
  list_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_seen <= words_seen + 1;
        if (word_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result word: status %0d item %h last %b",
                     m_tuser, m_tdata, m_tlast);
        end else begin
          want = word_q.pop_front();
          if (m_tuser !== want.status || m_tdata !== want.item || m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch: expected status %0d item %h last %b, got %0d %h %b",
                       want.status, want.item, want.last, m_tuser, m_tdata, m_tlast);
          end
        end
        stall_left = $urandom_range(0, sink_stall_max);
      end
      if (hold_off_asks != hold_off_seen) begin
        hold_off_seen = hold_off_asks;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** positional_list_engine: FAILED **");
      $finish;
    end
  end

endmodule
